// ===== rtl/assert_macros.svh =====
// Assertion helpers, all sampled on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TLCIL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLCIL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TLCIL_ASSERT(lbl, prop, msg)
`define TLCIL_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/tlcil_pkg.sv =====
`default_nettype none
package tlcil_pkg;

    // row operations of one cache level
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_TOUCH = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_INVAL = 2'd3;

    localparam logic [1:0] MODE_EXCL = 2'd0;
    localparam logic [1:0] MODE_INCL = 2'd1;
    localparam logic [1:0] MODE_NINE = 2'd2;
    // spare encoding, handled as non-inclusive non-exclusive
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam logic [1:0] REG_MODE_ADDR = 2'd0;

    typedef struct packed {
        logic       clr;
        logic       load_in;
        logic       rd_l2;
        logic       l2_use_v;
        logic [1:0] l2_op;
        logic       rd_l3;
        logic       l3_use_v;
        logic [1:0] l3_op;
        logic       ld_v2;
        logic       ld_v3;
        logic       ld_flags;
        logic       cnt_l2_hit;
        logic       cnt_l2_miss;
        logic       cnt_l3_hit;
        logic       cnt_l3_miss;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic in_ign;
        logic l2_hit;
        logic l3_hit;
        logic l2_vic;
        logic l3_vic;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/two_level_cache_inclusion_lru_top.sv =====
// An access reads both levels, then checks hits and updates rows (ignored ones skip
// this); a victim move into L3 adds an L3 read and fill, an inclusive back-invalidate
// an L2 read and invalidate, then an L2 read and fill. One access at a time, paced by
// read-modify-write passes on the tag memories; the next is taken once the result is
// output. Reset: counters, mode and valid state clear; a sweep of max(L2 sets, L3
// sets) sets (2048 by default) zeroes valid and recency rows before items are taken.
`default_nettype none
`include "assert_macros.svh"
module two_level_cache_inclusion_lru_top #(
    parameter int BLOCK_OFFSET_BITS = 6,
    parameter int L2_SET_COUNT      = 1024,
    parameter int L2_WAY_COUNT      = 8,
    parameter int L3_SET_COUNT      = 2048,
    parameter int L3_WAY_COUNT      = 16,
    parameter int ADDR_BITS         = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // access_type[7:0], address[ADDR_BITS+7:8], zero pad
    input  logic [((8+ADDR_BITS+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ignored[0], l2_hit[1], l3_hit[2], l2_hits_total[34:3], l2_misses_total[66:35],
    // l3_hits_total[98:67], l3_misses_total[130:99], zero pad
    output logic [135:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tlcil_pkg::*;

    cmd_t       cmd;
    status_t    status;
    logic [1:0] mode_reg;
    logic       o_ign, o_h2, o_h3;
    logic [31:0] o_l2h, o_l2m, o_l3h, o_l3m;

    assign pready = 1'b1;
    assign prdata = {30'd0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_EXCL;
        else if (psel && penable && pwrite && paddr == REG_MODE_ADDR)
            mode_reg <= pwdata[1:0];
    end

    tlcil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .mode     (mode_reg),
        .status   (status),
        .cmd      (cmd)
    );

    tlcil_dp #(
        .OFF (BLOCK_OFFSET_BITS),
        .L2S (L2_SET_COUNT),
        .L2W (L2_WAY_COUNT),
        .L3S (L3_SET_COUNT),
        .L3W (L3_WAY_COUNT),
        .AB  (ADDR_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_type         (s_tdata[7:0]),
        .in_addr         (s_tdata[8 +: ADDR_BITS]),
        .out_ignored     (o_ign),
        .out_l2_hit      (o_h2),
        .out_l3_hit      (o_h3),
        .out_l2_hits     (o_l2h),
        .out_l2_miss_cnt (o_l2m),
        .out_l3_hits     (o_l3h),
        .out_l3_miss_cnt (o_l3m)
    );

    assign m_tdata = {5'd0, o_l3m, o_l3h, o_l2m, o_l2h, o_h3, o_h2, o_ign};

    `TLCIL_NEVER(a_no_accept_in_clear, cmd.clr && s_tready, "item taken during clear sweep")
    `TLCIL_ASSERT(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "overlapping items")
    `TLCIL_ASSERT(a_out_free, cmd.out_load |-> (!m_tvalid || m_tready), "result overwritten")
    `TLCIL_NEVER(a_l2_rd_wr, cmd.rd_l2 && cmd.l2_op != OP_NONE, "L2 read and write together")
    `TLCIL_NEVER(a_l3_rd_wr, cmd.rd_l3 && cmd.l3_op != OP_NONE, "L3 read and write together")

endmodule
`default_nettype wire

// ===== rtl/tlcil_level.sv =====
`default_nettype none
module tlcil_level #(
    parameter int SETS = 1024,
    parameter int WAYS = 8,
    parameter int TAGW = 32
) (
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [$clog2(SETS)-1:0] rd_set,
    input  logic [1:0]              op,
    input  logic [TAGW-1:0]         tag,
    input  logic                    clr_en,
    input  logic [$clog2(SETS)-1:0] clr_set,
    output logic                    hit,
    output logic                    vic_valid,
    output logic [TAGW-1:0]         vic_tag
);
    import tlcil_pkg::*;

    localparam int SW = $clog2(SETS);
    localparam int RW = $clog2(WAYS);
    localparam int P  = 1 << RW;

    logic [WAYS-1:0][TAGW-1:0] tag_mem [SETS];
    logic [WAYS-1:0]           val_mem [SETS];
    logic [WAYS-1:0][RW-1:0]   rank_mem [SETS];

    logic [WAYS-1:0][TAGW-1:0] tag_q, tag_n;
    logic [WAYS-1:0]           val_q, val_n;
    logic [WAYS-1:0][RW-1:0]   rank_q, rank_n;
    logic [SW-1:0]             set_q;

    logic [RW-1:0] hit_way, free_way, lru_way, fill_way, way;
    logic          all_valid;
    logic [RW-1:0] t_rank [2*P];
    logic [RW-1:0] t_idx [2*P];
    logic          t_ok [2*P];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            tag_q  <= tag_mem[rd_set];
            val_q  <= val_mem[rd_set];
            rank_q <= rank_mem[rd_set];
            set_q  <= rd_set;
        end
        if (clr_en)
        begin
            val_mem[clr_set]  <= '0;
            rank_mem[clr_set] <= '0;
        end
        else if (op != OP_NONE)
        begin
            val_mem[set_q]  <= val_n;
            rank_mem[set_q] <= rank_n;
            if (op == OP_FILL)
                tag_mem[set_q] <= tag_n;
        end
    end

    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (val_q[w] && tag_q[w] == tag)
            begin
                hit     = 1'b1;
                hit_way = RW'(w);
            end
            if (!val_q[w])
                free_way = RW'(w);
        end
        all_valid = &val_q;
    end

    // LRU: earliest way with the smallest rank, via a min tree
    always_comb
    begin
        for (int i = 0; i < P; i++)
        begin
            t_ok[P+i]   = (i < WAYS);
            t_rank[P+i] = (i < WAYS) ? rank_q[i] : '0;
            t_idx[P+i]  = RW'(i);
        end
        t_ok[0]   = 1'b0;
        t_rank[0] = '0;
        t_idx[0]  = '0;
        for (int n = P - 1; n >= 1; n--)
        begin
            if (t_ok[2*n] && (!t_ok[2*n+1] || t_rank[2*n] <= t_rank[2*n+1]))
            begin
                t_ok[n]   = t_ok[2*n];
                t_rank[n] = t_rank[2*n];
                t_idx[n]  = t_idx[2*n];
            end
            else
            begin
                t_ok[n]   = t_ok[2*n+1];
                t_rank[n] = t_rank[2*n+1];
                t_idx[n]  = t_idx[2*n+1];
            end
        end
        lru_way = t_idx[1];
    end

    assign fill_way  = all_valid ? lru_way : free_way;
    assign vic_valid = all_valid;
    assign vic_tag   = tag_q[fill_way];

    always_comb
    begin
        case (op)
            OP_TOUCH: way = hit_way;
            OP_INVAL: way = hit_way;
            default:  way = fill_way;
        endcase
        val_n  = val_q;
        rank_n = rank_q;
        tag_n  = tag_q;
        if (op == OP_INVAL)
        begin
            if (hit)
                val_n[way] = 1'b0;
        end
        else
        begin
            for (int i = 0; i < WAYS; i++)
                if (rank_q[i] > rank_q[way])
                    rank_n[i] = rank_q[i] - 1'b1;
            rank_n[way] = RW'(WAYS - 1);
            if (op == OP_FILL)
            begin
                val_n[way] = 1'b1;
                tag_n[way] = tag;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tlcil_dp.sv =====
`default_nettype none
module tlcil_dp #(
    parameter int OFF = 6,
    parameter int L2S = 1024,
    parameter int L2W = 8,
    parameter int L3S = 2048,
    parameter int L3W = 16,
    parameter int AB  = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlcil_pkg::cmd_t    cmd,
    output tlcil_pkg::status_t status,
    input  logic [7:0]         in_type,
    input  logic [AB-1:0]      in_addr,
    output logic               out_ignored,
    output logic               out_l2_hit,
    output logic               out_l3_hit,
    output logic [31:0]        out_l2_hits,
    output logic [31:0]        out_l2_miss_cnt,
    output logic [31:0]        out_l3_hits,
    output logic [31:0]        out_l3_miss_cnt
);
    import tlcil_pkg::*;

    localparam int L2SW = $clog2(L2S);
    localparam int L3SW = $clog2(L3S);
    localparam int L2TW = AB - OFF - L2SW;
    localparam int L3TW = AB - OFF - L3SW;
    localparam int MAXS = (L2S > L3S) ? L2S : L3S;
    localparam int CW   = $clog2(MAXS);

    logic [AB-1:0] addr_reg, vaddr_reg;
    logic          ign_reg, h2_reg, h3_reg;
    logic [31:0]   l2h_reg, l2m_reg, l3h_reg, l3m_reg;
    logic [CW-1:0] clr_cnt_reg;

    logic [L2SW-1:0] l2_set;
    logic [L2TW-1:0] l2_tag, l2_vic_tag;
    logic [L3SW-1:0] l3_set;
    logic [L3TW-1:0] l3_tag, l3_vic_tag;
    logic            l2_hit, l3_hit, l2_vic, l3_vic;
    logic            l2_clr, l3_clr;

    assign l2_set = cmd.l2_use_v ? vaddr_reg[OFF +: L2SW] : addr_reg[OFF +: L2SW];
    assign l2_tag = cmd.l2_use_v ? vaddr_reg[AB-1 -: L2TW] : addr_reg[AB-1 -: L2TW];
    assign l3_set = cmd.l3_use_v ? vaddr_reg[OFF +: L3SW] : addr_reg[OFF +: L3SW];
    assign l3_tag = cmd.l3_use_v ? vaddr_reg[AB-1 -: L3TW] : addr_reg[AB-1 -: L3TW];

    assign l2_clr = cmd.clr && ({1'b0, clr_cnt_reg} < (CW+1)'(L2S));
    assign l3_clr = cmd.clr && ({1'b0, clr_cnt_reg} < (CW+1)'(L3S));

    tlcil_level #(.SETS(L2S), .WAYS(L2W), .TAGW(L2TW)) u_l2 (
        .clk       (clk),
        .rd_en     (cmd.rd_l2),
        .rd_set    (l2_set),
        .op        (cmd.l2_op),
        .tag       (l2_tag),
        .clr_en    (l2_clr),
        .clr_set   (clr_cnt_reg[L2SW-1:0]),
        .hit       (l2_hit),
        .vic_valid (l2_vic),
        .vic_tag   (l2_vic_tag)
    );

    tlcil_level #(.SETS(L3S), .WAYS(L3W), .TAGW(L3TW)) u_l3 (
        .clk       (clk),
        .rd_en     (cmd.rd_l3),
        .rd_set    (l3_set),
        .op        (cmd.l3_op),
        .tag       (l3_tag),
        .clr_en    (l3_clr),
        .clr_set   (clr_cnt_reg[L3SW-1:0]),
        .hit       (l3_hit),
        .vic_valid (l3_vic),
        .vic_tag   (l3_vic_tag)
    );

    assign status.clr_done = (clr_cnt_reg == CW'(MAXS - 1));
    assign status.in_ign   = (in_type == 8'd0);
    assign status.l2_hit   = l2_hit;
    assign status.l3_hit   = l3_hit;
    assign status.l2_vic   = l2_vic;
    assign status.l3_vic   = l3_vic;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            l2h_reg     <= '0;
            l2m_reg     <= '0;
            l3h_reg     <= '0;
            l3m_reg     <= '0;
        end
        else
        begin
            if (cmd.clr && !status.clr_done)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.cnt_l2_hit)
                l2h_reg <= l2h_reg + 32'd1;
            if (cmd.cnt_l2_miss)
                l2m_reg <= l2m_reg + 32'd1;
            if (cmd.cnt_l3_hit)
                l3h_reg <= l3h_reg + 32'd1;
            if (cmd.cnt_l3_miss)
                l3m_reg <= l3m_reg + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            addr_reg <= in_addr;
            ign_reg  <= status.in_ign;
            h2_reg   <= 1'b0;
            h3_reg   <= 1'b0;
        end
        if (cmd.ld_flags)
        begin
            h2_reg <= l2_hit;
            h3_reg <= !l2_hit && l3_hit;
        end
        if (cmd.ld_v2)
            vaddr_reg <= {l2_vic_tag, addr_reg[OFF +: L2SW], {OFF{1'b0}}};
        else if (cmd.ld_v3)
            vaddr_reg <= {l3_vic_tag, addr_reg[OFF +: L3SW], {OFF{1'b0}}};
        if (cmd.out_load)
        begin
            out_ignored     <= ign_reg;
            out_l2_hit      <= h2_reg;
            out_l3_hit      <= h3_reg;
            out_l2_hits     <= l2h_reg;
            out_l2_miss_cnt <= l2m_reg;
            out_l3_hits     <= l3h_reg;
            out_l3_miss_cnt <= l3m_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tlcil_ctrl.sv =====
`default_nettype none
module tlcil_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic [1:0]         mode,
    input  tlcil_pkg::status_t status,
    output tlcil_pkg::cmd_t    cmd
);
    import tlcil_pkg::*;

    localparam logic [3:0] ST_CLR     = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_RD      = 4'd2;
    localparam logic [3:0] ST_LOOK    = 4'd3;
    localparam logic [3:0] ST_V3RD    = 4'd4;
    localparam logic [3:0] ST_V3FILL  = 4'd5;
    localparam logic [3:0] ST_V2RD    = 4'd6;
    localparam logic [3:0] ST_V2INV   = 4'd7;
    localparam logic [3:0] ST_L2RD    = 4'd8;
    localparam logic [3:0] ST_L2FILL  = 4'd9;
    localparam logic [3:0] ST_DONE    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLR:
            begin
                cmd.clr = 1'b1;
                if (status.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = status.in_ign ? ST_DONE : ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd_l2  = 1'b1;
                cmd.rd_l3  = 1'b1;
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                cmd.ld_flags = 1'b1;
                state_next   = ST_DONE;
                if (status.l2_hit)
                begin
                    cmd.l2_op      = OP_TOUCH;
                    cmd.cnt_l2_hit = 1'b1;
                end
                else
                begin
                    cmd.cnt_l2_miss = 1'b1;
                    cmd.cnt_l3_hit  = status.l3_hit;
                    cmd.cnt_l3_miss = !status.l3_hit;
                    if (mode == MODE_EXCL)
                    begin
                        if (status.l3_hit)
                            cmd.l3_op = OP_INVAL;
                        cmd.l2_op = OP_FILL;
                        cmd.ld_v2 = 1'b1;
                        if (status.l2_vic)
                            state_next = ST_V3RD;
                    end
                    else if (mode == MODE_INCL)
                    begin
                        if (status.l3_hit)
                            cmd.l2_op = OP_FILL;
                        else
                        begin
                            cmd.l3_op = OP_FILL;
                            cmd.ld_v3 = 1'b1;
                            // a valid L3 victim must leave L2 before the fill
                            if (status.l3_vic)
                                state_next = ST_V2RD;
                            else
                                cmd.l2_op = OP_FILL;
                        end
                    end
                    else
                    begin
                        if (!status.l3_hit)
                            cmd.l3_op = OP_FILL;
                        cmd.l2_op = OP_FILL;
                        cmd.ld_v2 = 1'b1;
                        if (status.l2_vic)
                            state_next = ST_V3RD;
                    end
                end
            end
            ST_V3RD:
            begin
                cmd.rd_l3    = 1'b1;
                cmd.l3_use_v = 1'b1;
                state_next   = ST_V3FILL;
            end
            ST_V3FILL:
            begin
                cmd.l3_use_v = 1'b1;
                if (mode == MODE_EXCL || !status.l3_hit)
                    cmd.l3_op = OP_FILL;
                state_next = ST_DONE;
            end
            ST_V2RD:
            begin
                cmd.rd_l2    = 1'b1;
                cmd.l2_use_v = 1'b1;
                state_next   = ST_V2INV;
            end
            ST_V2INV:
            begin
                cmd.l2_use_v = 1'b1;
                cmd.l2_op    = OP_INVAL;
                state_next   = ST_L2RD;
            end
            ST_L2RD:
            begin
                cmd.rd_l2  = 1'b1;
                state_next = ST_L2FILL;
            end
            ST_L2FILL:
            begin
                cmd.l2_op  = OP_FILL;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
`default_nettype wire
